// ===== design/line_command_parser_defines.svh =====
// assertion macros for the line command parser
// used by the top level; expects clk and rst_n in scope
`ifndef LINE_COMMAND_PARSER_DEFINES_SVH
`define LINE_COMMAND_PARSER_DEFINES_SVH

// condition holds at every edge out of reset
`define LCP_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("lcp: invariant violated");

// consequent holds in the same cycle as the antecedent
`define LCP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lcp: implication violated");

// consequent holds in the cycle after the antecedent
`define LCP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lcp: next-cycle implication violated");

`endif

// ===== design/lcp_pkg.sv =====
// shared types, constants and command tables of the line command parser
// no dependencies
package lcp_pkg;

  // one past the longest line accepted, newline excluded
  localparam int MAX_LINE = 1024;
  localparam int POS_W    = $clog2(MAX_LINE + 1);

  localparam int NCMD          = 6;
  localparam int CMD_PERIOD    = 5;
  localparam int PERIOD_PREFIX = 7;
  localparam int PERIOD_W      = 31;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;

  localparam logic [7:0] BYTE_NL  = 8'h0a;
  localparam logic [7:0] BYTE_EOI = 8'hff;
  localparam logic [7:0] BYTE_D0  = 8'h30;
  localparam logic [7:0] BYTE_D9  = 8'h39;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = PERIOD_W;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_PERIOD  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_CELSIUS = 1'b1;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 31'd1;

  typedef enum logic [2:0] {
    CODE_OFF     = 3'd0,
    CODE_STOP    = 3'd1,
    CODE_START   = 3'd2,
    CODE_SCALE_F = 3'd3,
    CODE_SCALE_C = 3'd4,
    CODE_PERIOD  = 3'd5,
    CODE_INVALID = 3'd6,
    CODE_EOI     = 3'd7
  } code_t;

  typedef logic [NCMD-1:0] cand_mask_t;

  // length of each command text
  function automatic logic [2:0] cmd_len(input logic [2:0] k);
    logic [2:0] len;
    unique case (k)
      3'd0:    len = 3'd3;
      3'd1:    len = 3'd4;
      3'd2:    len = 3'd5;
      default: len = 3'd7;
    endcase
    return len;
  endfunction

  // character i of command k, first character at index 0
  function automatic logic [7:0] cmd_char(input logic [2:0] k, input logic [2:0] i);
    logic [0:7][7:0] txt;
    unique case (k)
      3'd0:    txt = {"OFF", 40'h0};
      3'd1:    txt = {"STOP", 32'h0};
      3'd2:    txt = {"START", 24'h0};
      3'd3:    txt = {"SCALE=F", 8'h0};
      3'd4:    txt = {"SCALE=C", 8'h0};
      3'd5:    txt = {"PERIOD=", 8'h0};
      default: txt = '0;
    endcase
    return txt[i];
  endfunction

endpackage

// ===== design/line_command_parser.sv =====
// line command parser top level: byte stream in, command results out
// depends on lcp_pkg and line_command_parser_defines.svh
//
// Takes one received byte per word and recognises newline-ended command lines
// (OFF, STOP, START, SCALE=F, SCALE=C, PERIOD=<digits>) without buffering the
// line. A byte is accepted every cycle while the result side keeps up; the
// byte is held in an input register, its single-pass update of the match
// mask, line position and saturating period value is registered in the
// parser state, and any result it gives is written to the result register,
// which offers it. Only newline and the 0xff end-of-input byte give a
// result; each carries the command code in tuser and the settings in force
// after the command in tdata. OFF, an invalid or over-long line and end of
// input halt the block: later bytes are consumed and dropped until reset.
// Config writes to the initial period and scale load the live settings at
// once and should only be made while no byte is in flight.
`include "line_command_parser_defines.svh"

module line_command_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  // config write port
  input  logic                          cfg_wr_en,
  input  logic [lcp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lcp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // byte input
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] rx_byte
  // result output
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [39:0]                   out_tdata,  // [30:0] period_value, [31] report_enable,
                                                    // [32] celsius_scale, [39:33] zero
  output logic [2:0]                    out_tuser   // [2:0] command_code
);
  import lcp_pkg::*;

  // input register
  logic [7:0]          byte_r;
  logic                byte_vld_r;

  // parser state
  cand_mask_t          mask_r,   mask_nxt;
  logic [POS_W-1:0]    pos_r,    pos_nxt;
  logic [PERIOD_W-1:0] acc_r,    acc_nxt;
  logic [PERIOD_W-1:0] period_r, period_nxt;
  logic                scale_r,  scale_nxt;
  logic                report_r, report_nxt;
  logic                halted_r, halted_nxt;

  // result register
  logic                out_vld_r;
  code_t               out_code_r;
  logic [PERIOD_W-1:0] out_period_r;
  logic                out_report_r;
  logic                out_scale_r;

  logic                advance;
  logic                proc;
  logic                res_vld;
  code_t               res_code;
  code_t               found;
  logic                keep;
  logic                is_digit;
  logic [PERIOD_W+3:0] prod;

  // pipeline handshake
  assign advance   = !out_vld_r || out_tready;
  assign proc      = byte_vld_r && advance;
  assign in_tready = !byte_vld_r || advance;

  assign is_digit = (byte_r >= BYTE_D0) && (byte_r <= BYTE_D9);
  // acc * 10 + digit, widened so saturation can be detected
  assign prod = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0}
              + {(PERIOD_W + 0)'(0), 4'(byte_r - BYTE_D0)};

  // single-pass byte update
  always_comb begin
    mask_nxt   = mask_r;
    pos_nxt    = pos_r;
    acc_nxt    = acc_r;
    period_nxt = period_r;
    scale_nxt  = scale_r;
    report_nxt = report_r;
    halted_nxt = halted_r;
    res_vld    = 1'b0;
    res_code   = CODE_INVALID;
    found      = CODE_INVALID;
    keep       = 1'b0;
    if (proc && !halted_r) begin
      priority if (byte_r == BYTE_EOI) begin
        halted_nxt = 1'b1;
        mask_nxt   = '0;
        res_vld    = 1'b1;
        res_code   = CODE_EOI;
      end else if (byte_r == BYTE_NL) begin
        // resolve the line, lowest command index wins
        if (pos_r < POS_W'(MAX_LINE)) begin
          for (int k = NCMD - 1; k >= 0; k--) begin
            if (mask_r[k]) begin
              if (k == CMD_PERIOD) begin
                if (pos_r >= POS_W'(PERIOD_PREFIX)) found = code_t'(3'(k));
              end else if (pos_r == POS_W'(cmd_len(3'(k)))) begin
                found = code_t'(3'(k));
              end
            end
          end
        end
        unique case (found)
          CODE_STOP:    report_nxt = 1'b0;
          CODE_START:   report_nxt = 1'b1;
          CODE_SCALE_F: scale_nxt  = 1'b0;
          CODE_SCALE_C: scale_nxt  = 1'b1;
          CODE_PERIOD:  period_nxt = acc_r;
          default:      halted_nxt = 1'b1;
        endcase
        mask_nxt = '1;
        pos_nxt  = '0;
        acc_nxt  = '0;
        res_vld  = 1'b1;
        res_code = found;
      end else if (pos_r >= POS_W'(MAX_LINE)) begin
        // over-long line can no longer match
        mask_nxt = '0;
      end else begin
        // drop candidates that this byte rules out
        for (int k = 0; k < NCMD; k++) begin
          if (pos_r < POS_W'(cmd_len(3'(k))))
            keep = (byte_r == cmd_char(3'(k), pos_r[2:0]));
          else
            keep = (k == CMD_PERIOD) && is_digit;
          mask_nxt[k] = mask_r[k] && keep;
        end
        // period digits accumulate with saturation
        if (mask_nxt[CMD_PERIOD] && pos_r >= POS_W'(PERIOD_PREFIX))
          acc_nxt = (prod > {4'b0000, PERIOD_MAX}) ? PERIOD_MAX : prod[PERIOD_W-1:0];
        pos_nxt = pos_r + POS_W'(1);
      end
    end
  end

  // control and settings registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r <= 1'b0;
      mask_r     <= '1;
      pos_r      <= '0;
      acc_r      <= '0;
      period_r   <= PERIOD_RESET;
      scale_r    <= 1'b0;
      report_r   <= 1'b1;
      halted_r   <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (in_tready) byte_vld_r <= in_tvalid;
      mask_r   <= mask_nxt;
      pos_r    <= pos_nxt;
      acc_r    <= acc_nxt;
      report_r <= report_nxt;
      halted_r <= halted_nxt;
      priority if (cfg_wr_en && cfg_index == REG_INITIAL_PERIOD) begin
        period_r <= cfg_wdata;
        scale_r  <= scale_nxt;
      end else if (cfg_wr_en && cfg_index == REG_INITIAL_CELSIUS) begin
        period_r <= period_nxt;
        scale_r  <= cfg_wdata[0];
      end else begin
        period_r <= period_nxt;
        scale_r  <= scale_nxt;
      end
      if (advance) out_vld_r <= res_vld;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) byte_r <= in_tdata;
    if (advance && res_vld) begin
      out_code_r   <= res_code;
      out_period_r <= period_nxt;
      out_report_r <= report_nxt;
      out_scale_r  <= scale_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_code_r;
  assign out_tdata  = {7'b0000000, out_scale_r, out_report_r, out_period_r};

  // checks
  `LCP_ASSERT_NEXT(a_halt_sticks, halted_r, halted_r)
  `LCP_ASSERT_ALWAYS(a_pos_bounded, pos_r <= POS_W'(MAX_LINE))
  `LCP_ASSERT_IMPL(a_line_start_all, pos_r == '0 && !halted_r, mask_r == '1)
  `LCP_ASSERT_IMPL(a_halting_code, out_vld_r && (out_code_r == CODE_OFF ||
                   out_code_r == CODE_INVALID || out_code_r == CODE_EOI), halted_r)

endmodule

// ===== tb/sv/line_command_parser_test.sv =====
// self-checking bench for line_command_parser: command lines in, decoded results out
// depends on lcp_pkg and the line_command_parser top level; a scoreboard class
// predicts each result from the accepted bytes and checks the result words
module line_command_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lcp_pkg::*;

  typedef struct {
    code_t               code;
    logic [PERIOD_W-1:0] period;
    logic                report;
    logic                celsius;
  } cmd_result_t;

  // ways the run ends; all halt the parser for good, unless an altered command stays valid
  typedef enum int {
    END_OFF, END_EOI, END_EMPTY, END_GARBAGE, END_LONG, END_BROKEN
  } ending_t;

  // tracks the parser state and holds the results still owed
  class command_scoreboard;
    string               cmd_text[NCMD];
    cand_mask_t          alive;
    int                  line_pos;
    logic [PERIOD_W-1:0] digit_value;
    logic [PERIOD_W-1:0] period;
    bit                  report_on;
    bit                  celsius;
    bit                  halted;
    cmd_result_t         expected_q[$];
    int                  errors;
    int                  bytes_taken;

    function new();
      cmd_text    = '{"OFF", "STOP", "START", "SCALE=F", "SCALE=C", "PERIOD="};
      period      = PERIOD_RESET;
      celsius     = 1'b0;
      report_on   = 1'b1;
      halted      = 1'b0;
      errors      = 0;
      bytes_taken = 0;
      start_line();
    endfunction

    function void start_line();
      alive       = '1;
      line_pos    = 0;
      digit_value = '0;
    endfunction

    function void push(code_t code);
      cmd_result_t r;
      r.code    = code;
      r.period  = period;
      r.report  = report_on;
      r.celsius = celsius;
      expected_q.push_back(r);
    endfunction

    // register writes load the live settings at once
    function void load_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      if (idx == REG_INITIAL_PERIOD)
        period = value[PERIOD_W-1:0];
      else if (idx == REG_INITIAL_CELSIUS)
        celsius = value[0];
    endfunction

    // narrow the candidate set by one byte of the line
    function void match_byte(logic [7:0] b);
      longint unsigned grown;
      bit              keep;
      if (line_pos >= MAX_LINE) begin
        alive = '0;
        return;
      end
      for (int k = 0; k < NCMD; k++) begin
        if (!alive[k])
          continue;
        if (line_pos < cmd_text[k].len())
          keep = (b == cmd_text[k][line_pos]);
        else
          keep = (k == CMD_PERIOD) && (b >= BYTE_D0) && (b <= BYTE_D9);
        if (!keep)
          alive[k] = 1'b0;
      end
      // saturating decimal value behind the period prefix
      if (alive[CMD_PERIOD] && line_pos >= PERIOD_PREFIX) begin
        grown = 64'(digit_value) * 10 + 64'(b - BYTE_D0);
        digit_value = (grown > 64'(PERIOD_MAX)) ? PERIOD_MAX : grown[PERIOD_W-1:0];
      end
      line_pos++;
    endfunction

    // newline: resolve the line into a command and apply it
    function void close_line();
      code_t found;
      found = CODE_INVALID;
      if (line_pos < MAX_LINE) begin
        for (int k = 0; k < NCMD; k++) begin
          if (alive[k] && ((k == CMD_PERIOD) ? (line_pos >= PERIOD_PREFIX)
                                             : (line_pos == cmd_text[k].len()))) begin
            found = code_t'(k);
            break;
          end
        end
      end
      case (found)
        CODE_STOP:    report_on = 1'b0;
        CODE_START:   report_on = 1'b1;
        CODE_SCALE_F: celsius = 1'b0;
        CODE_SCALE_C: celsius = 1'b1;
        CODE_PERIOD:  period = digit_value;
        default:      halted = 1'b1;
      endcase
      start_line();
      push(found);
    endfunction

    function void note_byte(logic [7:0] b);
      bytes_taken++;
      if (halted)
        return;
      if (b == BYTE_EOI) begin
        halted = 1'b1;
        alive  = '0;
        push(CODE_EOI);
      end else if (b == BYTE_NL) begin
        close_line();
      end else begin
        match_byte(b);
      end
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h got %0h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [2:0] code, logic [39:0] word);
      cmd_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none got code %0h tdata %0h",
                 $time, code, word);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare("command_code", 64'(want.code), 64'(code));
      compare("period_value", 64'(want.period), 64'(word[30:0]));
      compare("report_enable", 64'(want.report), 64'(word[31]));
      compare("celsius_scale", 64'(want.celsius), 64'(word[32]));
      compare("tdata padding", 64'd0, 64'(word[39:33]));
    endfunction
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                  in_tvalid  = 1'b0;
  logic [7:0]            in_tdata   = '0;
  logic                  out_tready = 1'b0;
  logic                  in_tready;
  logic                  out_tvalid;
  logic [39:0]           out_tdata;
  logic [2:0]            out_tuser;

  // no random idling on either side while set
  bit steady = 1'b0;

  command_scoreboard sb = new();

  line_command_parser DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // hard stop in case the parser hangs
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // result side: random stalls, one long hold-off once traffic is flowing
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && sb.bytes_taken >= 300) begin
        hold_done = 1'b1;
        hold_left = 200;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (steady) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= 19);
      end
    end
  end

  // every accepted result word goes to the scoreboard
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tuser, out_tdata);
  end

  // offer one byte and wait for it to be taken
  task automatic put_byte(input logic [7:0] b);
    while (!steady && $urandom_range(99) < 19) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    sb.note_byte(b);
  endtask

  task automatic put_text(input string s, input bit ends_line);
    for (int i = 0; i < s.len(); i++)
      put_byte(s[i]);
    if (ends_line)
      put_byte(BYTE_NL);
  endtask

  task automatic put_digits(input int count);
    repeat (count) put_byte(BYTE_D0 + 8'($urandom_range(0, 9)));
  endtask

  // sender holds off until every owed result has come out
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write both registers on back-to-back edges
  task automatic write_settings(input logic [CFG_DATA_W-1:0] period_word,
                                input logic [CFG_DATA_W-1:0] scale_word);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_INITIAL_PERIOD;
    cfg_wdata <= period_word;
    @(posedge clk);
    sb.load_setting(REG_INITIAL_PERIOD, period_word);
    cfg_index <= REG_INITIAL_CELSIUS;
    cfg_wdata <= scale_word;
    @(posedge clk);
    sb.load_setting(REG_INITIAL_CELSIUS, scale_word);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    code_t   pick;
    ending_t ending;
    string   word_text;
    int      r;
    int      n;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed lines under the reset settings
    put_text("STOP", 1'b1);
    put_text("SCALE=C", 1'b1);
    put_text("START", 1'b1);
    put_text("SCALE=F", 1'b1);
    put_text("PERIOD=", 1'b1);
    put_text("PERIOD=2147483647", 1'b1);
    put_text("PERIOD=2147483648", 1'b1);
    put_text("PERIOD=0999999999999", 1'b1);

    // random well-formed commands over several register settings
    for (int phase = 0; phase < 6; phase++) begin
      wait_drained();
      case (phase)
        0:       write_settings(PERIOD_MAX, 31'd1);
        1:       write_settings('0, '0);
        3:       write_settings(31'd1, 31'h7fff_fffe);
        default: write_settings(31'($urandom), 31'($urandom));
      endcase
      steady = (phase == 2);
      while (sb.bytes_taken < 60 + (phase + 1) * 130) begin
        pick = code_t'($urandom_range(CODE_STOP, CODE_PERIOD));
        put_text(sb.cmd_text[pick], pick != CODE_PERIOD);
        if (pick == CODE_PERIOD) begin
          r = $urandom_range(99);
          if (r < 80)
            put_digits($urandom_range(0, 6));
          else if (r < 95)
            put_digits($urandom_range(7, 10));
          else
            put_digits($urandom_range(11, 14));
          put_byte(BYTE_NL);
        end
      end
    end
    steady = 1'b0;
    wait_drained();
    write_settings(31'($urandom), 31'($urandom));

    // finish with one of the halting cases
    ending = ending_t'($urandom_range(END_OFF, END_BROKEN));
    case (ending)
      END_OFF: begin
        put_text(sb.cmd_text[CODE_OFF], 1'b1);
      end
      END_EOI: begin
        repeat ($urandom_range(0, 6)) put_byte(8'($urandom_range(0, 254)));
        put_byte(BYTE_EOI);
      end
      END_EMPTY: begin
        put_byte(BYTE_NL);
      end
      END_GARBAGE: begin
        // zero byte inside a command prefix, then random bytes
        word_text = sb.cmd_text[CODE_START];
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++)
          put_byte(word_text[i]);
        put_byte(8'h00);
        repeat ($urandom_range(0, 6)) put_byte(8'($urandom_range(0, 254)));
        put_byte(BYTE_NL);
      end
      END_LONG: begin
        // longest line still accepted, then one at or past the limit
        put_text(sb.cmd_text[CODE_PERIOD], 1'b0);
        put_digits(MAX_LINE - 1 - PERIOD_PREFIX);
        put_byte(BYTE_NL);
        put_text(sb.cmd_text[CODE_PERIOD], 1'b0);
        put_digits(MAX_LINE - PERIOD_PREFIX + $urandom_range(0, 3));
        put_byte(BYTE_NL);
      end
      default: begin
        // truncated, extended or altered command
        word_text = sb.cmd_text[$urandom_range(0, NCMD - 1)];
        case ($urandom_range(0, 2))
          0: put_text(word_text.substr(0, $urandom_range(0, word_text.len() - 2)), 1'b1);
          1: begin
            put_text(word_text, 1'b0);
            if ($urandom_range(1))
              put_digits($urandom_range(1, 3));
            put_byte(8'($urandom_range(8'h41, 8'h5a)));
            put_byte(BYTE_NL);
          end
          default: begin
            word_text[$urandom_range(0, word_text.len() - 1)] = byte'($urandom_range(1, 254));
            put_text(word_text, 1'b1);
          end
        endcase
      end
    endcase

    // bytes after the halt are dropped without a result
    put_byte(BYTE_EOI);
    put_byte(8'h80);
    repeat (24) put_byte(8'($urandom_range(0, 255)));
    put_byte(BYTE_NL);

    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/lcp_pkg.sv
design/line_command_parser.sv
tb/sv/line_command_parser_test.sv
